FILE: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stream find-and-replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_REPL    = 8;
  localparam int CMD_BYTES   = (MAX_PATTERN > MAX_REPL) ? MAX_PATTERN : MAX_REPL;

  localparam int CNT_W     = $clog2(MAX_PATTERN + 1);
  localparam int RCNT_W    = $clog2(MAX_REPL + 1);
  localparam int CMD_CNT_W = $clog2(CMD_BYTES + 1);
  localparam int CMD_IDX_W = (CMD_BYTES > 1) ? $clog2(CMD_BYTES) : 1;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int LEN_W      = 4;

  typedef logic [7:0] octet_t;

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES = 2'd0,
    REG_PATTERN_LEN   = 2'd1,
    REG_REPL_BYTES    = 2'd2,
    REG_REPL_LEN      = 2'd3
  } reg_idx_t;

  // configuration as seen by the matcher, lengths already clamped
  typedef struct packed {
    octet_t [MAX_PATTERN-1:0] pat;
    logic   [CNT_W-1:0]       plen;
    octet_t [MAX_REPL-1:0]    repl;
    logic   [RCNT_W-1:0]      rlen;
  } cfg_t;

  // one queued command: emit the first cnt bytes of data
  typedef struct packed {
    octet_t [CMD_BYTES-1:0] data;
    logic   [CMD_CNT_W-1:0] cnt;
    logic                   last;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// Holds the pending window, matches it against the pattern and turns each
// input word into one command of bytes to emit.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_front (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire  sfr_pkg::cfg_t     cfg,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [7:0]              in_byte,
  input  wire                     in_last,
  input  wire                     q_full,
  output logic                    q_push,
  output sfr_pkg::cmd_t           q_cmd,
  output logic [sfr_pkg::CNT_W-1:0] win_cnt
);
  import sfr_pkg::*;

  octet_t [MAX_PATTERN-1:0] win_r, win_nxt;
  logic   [CNT_W-1:0]       cnt_r, cnt_nxt;

  octet_t [MAX_PATTERN-1:0] wp;
  logic   [MAX_PATTERN-1:0] mj;
  logic   [CNT_W-1:0]       c;
  logic   [CNT_W-1:0]       k;
  logic                     flush;
  logic                     full_match;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign win_cnt  = cnt_r;

  always_comb begin
    c = cnt_r + CNT_W'(1);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      wp[i] = (int'(cnt_r) == i) ? in_byte : win_r[i];
    end
    // mj[j]: window with the oldest j bytes dropped is a pattern prefix
    for (int j = 0; j < MAX_PATTERN; j++) begin
      mj[j] = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if ((j + i < MAX_PATTERN) && (j + i < int'(c)) && (wp[j+i] != cfg.pat[i])) begin
          mj[j] = 1'b0;
        end
      end
    end
    k = c;
    for (int j = MAX_PATTERN - 1; j >= 0; j--) begin
      if ((j < int'(c)) && mj[j]) begin
        k = CNT_W'(j);
      end
    end
    flush      = c > cfg.plen;
    full_match = (c == cfg.plen) && mj[0];
  end

  always_comb begin
    q_cmd.data = '0;
    q_cmd.last = in_last;
    priority if (full_match && !flush) begin
      for (int i = 0; i < MAX_REPL; i++) begin
        q_cmd.data[i] = cfg.repl[i];
      end
      q_cmd.cnt = CMD_CNT_W'(cfg.rlen);
    end else if (flush || in_last) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        q_cmd.data[i] = wp[i];
      end
      q_cmd.cnt = CMD_CNT_W'(c);
    end else begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        q_cmd.data[i] = wp[i];
      end
      q_cmd.cnt = CMD_CNT_W'(k);
    end
  end

  // keep what can still start a match, oldest first
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_nxt[i] = win_r[i];
      for (int s = 0; s < MAX_PATTERN; s++) begin
        if ((int'(k) == s) && (i + s < MAX_PATTERN)) begin
          win_nxt[i] = wp[i+s];
        end
      end
    end
    if (flush || full_match || in_last) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = c - k;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (q_push) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      win_r <= win_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sfr_queue.sv
// ----------------------------------------------------------------------------
// sfr_queue
// Two-entry command queue between the matcher and the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  wire sfr_pkg::cmd_t push_cmd,
  input  wire                pop,
  output logic               full,
  output logic               head_valid,
  output sfr_pkg::cmd_t      head
);
  import sfr_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = count_r == 2'd2;
  assign head_valid = count_r != 2'd0;
  assign head       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// Walks the head command byte by byte into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                head_valid,
  input  wire sfr_pkg::cmd_t head,
  output logic               pop,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [7:0]         out_byte,
  output logic               out_has_byte,
  output logic               out_last
);
  import sfr_pkg::*;

  logic [CMD_IDX_W-1:0] idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  octet_t               out_byte_r, out_byte_nxt;
  logic                 has_byte_r, has_byte_nxt;
  logic                 last_r, last_nxt;
  logic                 slot_free;
  logic                 at_end;

  assign slot_free = !out_valid_r || out_ready;
  assign at_end    = CMD_CNT_W'(idx_r) == head.cnt - CMD_CNT_W'(1);

  always_comb begin
    pop           = 1'b0;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    has_byte_nxt  = has_byte_r;
    last_nxt      = last_r;
    if (head_valid && slot_free) begin
      if (head.cnt == '0) begin
        // nothing to emit; a last word still needs its end marker
        pop = 1'b1;
        if (head.last) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = '0;
          has_byte_nxt  = 1'b0;
          last_nxt      = 1'b1;
        end
      end else begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = head.data[idx_r];
        has_byte_nxt  = 1'b1;
        last_nxt      = head.last && at_end;
        if (at_end) begin
          pop     = 1'b1;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + CMD_IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    has_byte_r <= has_byte_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_has_byte = has_byte_r;
  assign out_last     = last_r;

endmodule

`default_nettype wire

FILE: rtl/stream_find_and_replace_top.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace_top
// Replaces every leftmost, non-overlapping occurrence of a pattern of up to
// eight bytes in a byte stream with a replacement of up to eight bytes.
//
// Input channel in_*: one text byte per word, in_last on the final byte.
// Output channel out_*: one byte per word; out_has_byte low marks an empty
// end-of-text word, sent only when the last input word emits nothing.
// The matcher takes one input word per cycle whenever the two-entry command
// queue has room; each word becomes one command of zero to eight bytes.
// The emitter sends one output word per cycle while out_ready is high, so
// a word that expands to n bytes holds the emitter until all n are sent,
// and the input stalls once the queue fills behind it.
// The first output byte passes through a queue entry and the output register.
// Registers sit on an APB-style port at byte addresses 0, 8, 16 and 24:
// pattern bytes, pattern length, replacement bytes, replacement length.
// Reset clears all registers, the pending window and the queue; no clearing
// pass is needed. When out_ready is low the output word holds and the queue
// absorbs up to two more input words before in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_and_replace_top (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [sfr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire  [sfr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [sfr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [7:0]                       in_byte,
  input  wire                              in_last,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [7:0]                       out_byte,
  output logic                             out_has_byte,
  output logic                             out_last
);
  import sfr_pkg::*;

  logic [63:0]      pat_bytes_r;
  logic [LEN_W-1:0] pat_len_r;
  logic [63:0]      repl_bytes_r;
  logic [LEN_W-1:0] repl_len_r;
  logic             wr_en;
  reg_idx_t         reg_sel;

  cfg_t             cfg;
  cmd_t             push_cmd;
  cmd_t             head;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             head_valid;
  logic [CNT_W-1:0] win_cnt;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r  <= '0;
      pat_len_r    <= '0;
      repl_bytes_r <= '0;
      repl_len_r   <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PATTERN_BYTES: pat_bytes_r  <= pwdata;
        REG_PATTERN_LEN:   pat_len_r    <= pwdata[LEN_W-1:0];
        REG_REPL_BYTES:    repl_bytes_r <= pwdata;
        REG_REPL_LEN:      repl_len_r   <= pwdata[LEN_W-1:0];
        default:           pat_len_r    <= pat_len_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PATTERN_BYTES: prdata = pat_bytes_r;
      REG_PATTERN_LEN:   prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, pat_len_r};
      REG_REPL_BYTES:    prdata = repl_bytes_r;
      REG_REPL_LEN:      prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, repl_len_r};
      default:           prdata = '0;
    endcase
  end

  // oversized lengths act as the maximum
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      cfg.pat[i] = pat_bytes_r[8*(i%8) +: 8];
    end
    for (int i = 0; i < MAX_REPL; i++) begin
      cfg.repl[i] = repl_bytes_r[8*(i%8) +: 8];
    end
    cfg.plen = (int'(pat_len_r) > MAX_PATTERN) ? CNT_W'(MAX_PATTERN) : CNT_W'(pat_len_r);
    cfg.rlen = (int'(repl_len_r) > MAX_REPL) ? RCNT_W'(MAX_REPL) : RCNT_W'(repl_len_r);
  end

  sfr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd),
    .win_cnt  (win_cnt)
  );

  sfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  sfr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_last     (out_last)
  );

  // an empty word is only ever the end marker, and carries a zero byte
  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_last && (out_byte == 8'd0))
    else $error("empty output word without last mark");

  // the window is empty after the final byte of a text
  a_last_clears_window: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> win_cnt == '0)
    else $error("pending window not flushed at end of text");

  // the window never holds MAX_PATTERN bytes between words
  a_window_short: assert property (@(posedge clk) disable iff (!rst_n)
    int'(win_cnt) < MAX_PATTERN)
    else $error("pending window overfull");

  // the command queue is only popped while it holds a command
  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> head_valid)
    else $error("command queue popped while empty");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stream_find_and_replace_top. Text words go in on a
// valid/ready channel with random gaps while the output side stalls at random.
// A software copy of the matcher predicts every output word. Registers are
// written over the APB-style port between phases. A short directed table comes
// first, then random phases built around the configured pattern.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;

  typedef struct packed {
    octet_t data;
    logic   has;
    logic   last;
  } out_word_t;

  typedef struct packed {
    bit        is_cfg;
    reg_idx_t  ridx;
    logic [63:0] val;
    octet_t    b;
    logic      l;
    bit        typed;
    out_word_t want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n        = 1'b0;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr        = '0;
  logic [CFG_DATA_W-1:0] pwdata       = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_byte      = 8'h00;
  logic                  in_last      = 1'b0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [7:0]            out_byte;
  logic                  out_has_byte;
  logic                  out_last;

  // shadow of the block's registers and pending window
  logic [63:0] pat_bytes  = '0;
  logic [3:0]  pat_len    = '0;
  logic [63:0] repl_bytes = '0;
  logic [3:0]  repl_len   = '0;
  octet_t      window [MAX_PATTERN];
  int          held       = 0;

  out_word_t   out_words_due [$];
  stim_row_t   dir_rows [$];
  out_word_t   head;
  bit          failed     = 1'b0;
  bit          in_calm    = 1'b0;
  bit          rdy_calm   = 1'b0;
  bit          rdy_state  = 1'b0;
  int          rdy_left   = 0;

  stream_find_and_replace_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic out_word_t mk_word(octet_t d, logic h, logic l);
    out_word_t w;
    w.data = d;
    w.has  = h;
    w.last = l;
    return w;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit prefix_ok(int n);
    int i;
    for (i = 0; i < n; i++)
      if (window[i] != pat_bytes[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // one text byte through the matcher; results queued when keep is set
  function automatic void predict_replace(octet_t b, bit l, bit keep);
    int        plen;
    int        rlen;
    int        k;
    out_word_t w;
    out_word_t res [$];
    plen = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
    rlen = (repl_len > MAX_REPL) ? MAX_REPL : int'(repl_len);
    if (held + 1 > plen) begin
      // no pattern, or window outgrew a shortened pattern
      for (k = 0; k < held; k++) res.push_back(mk_word(window[k], 1'b1, 1'b0));
      res.push_back(mk_word(b, 1'b1, 1'b0));
      held = 0;
    end else begin
      window[held] = b;
      held++;
      if (held == plen && prefix_ok(plen)) begin
        for (k = 0; k < rlen; k++) res.push_back(mk_word(repl_bytes[8*k +: 8], 1'b1, 1'b0));
        held = 0;
      end else begin
        while (held > 0 && !prefix_ok(held)) begin
          res.push_back(mk_word(window[0], 1'b1, 1'b0));
          for (k = 1; k < held; k++) window[k-1] = window[k];
          held--;
        end
      end
    end
    if (l) begin
      for (k = 0; k < held; k++) res.push_back(mk_word(window[k], 1'b1, 1'b0));
      held = 0;
      if (res.size() == 0) begin
        res.push_back(mk_word(8'h00, 1'b0, 1'b1));
      end else begin
        w = res.pop_back();
        w.last = 1'b1;
        res.push_back(w);
      end
    end
    if (keep)
      foreach (res[k]) out_words_due.push_back(res[k]);
  endfunction

  function automatic void row_cfg(reg_idx_t r, logic [63:0] v);
    stim_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.ridx   = r;
    s.val    = v;
    dir_rows.push_back(s);
  endfunction

  function automatic void row_in(octet_t b, logic l);
    stim_row_t s;
    s = '0;
    s.b = b;
    s.l = l;
    dir_rows.push_back(s);
  endfunction

  function automatic void row_chk(octet_t b, logic l, octet_t eb, logic eh, logic el);
    stim_row_t s;
    s = '0;
    s.b     = b;
    s.l     = l;
    s.typed = 1'b1;
    s.want  = mk_word(eb, eh, el);
    dir_rows.push_back(s);
  endfunction

  task automatic send_word(octet_t b, logic l);
    int gap;
    gap = in_calm ? 0 : idle_len();
    if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drain all outstanding words, then let words that emit nothing clear the queue
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (out_words_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t r, logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_PATTERN_BYTES: pat_bytes  = v;
      REG_PATTERN_LEN:   pat_len    = v[3:0];
      REG_REPL_BYTES:    repl_bytes = v;
      REG_REPL_LEN:      repl_len   = v[3:0];
      default: ;
    endcase
  endtask

  // output checker and ready pattern
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (out_words_due.size() == 0) begin
        $error("unexpected word: out_byte %h out_has_byte %b out_last %b",
               out_byte, out_has_byte, out_last);
        failed = 1'b1;
      end else begin
        head = out_words_due.pop_front();
        if (out_byte !== head.data) begin
          $error("out_byte: expected %h, got %h", head.data, out_byte);
          failed = 1'b1;
        end
        if (out_has_byte !== head.has) begin
          $error("out_has_byte: expected %b, got %b", head.has, out_has_byte);
          failed = 1'b1;
        end
        if (out_last !== head.last) begin
          $error("out_last: expected %b, got %b", head.last, out_last);
          failed = 1'b1;
        end
      end
    end
    if (rdy_left == 0) begin
      rdy_state = rdy_calm ? 1'b1 : ($urandom_range(0, 2) != 0);
      rdy_left  = rdy_state ? $urandom_range(1, 12) : $urandom_range(0, 6) == 0 ?
                  $urandom_range(10, 40) : $urandom_range(1, 3);
      if ($urandom_range(0, 19) == 0) rdy_calm = !rdy_calm;
    end else begin
      rdy_left--;
    end
    out_ready <= rdy_state;
  end

  initial begin
    int        sent;
    int        len;
    int        plen;
    int        k;
    int        r;
    bit        with_last;
    octet_t    alph [3];
    octet_t    txt [$];
    logic [63:0] v;

    // after reset the pattern is empty, so words pass straight through
    row_chk(8'h00, 1'b0, 8'h00, 1'b1, 1'b0);
    row_chk(8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1);
    row_cfg(REG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
    row_cfg(REG_PATTERN_LEN,   64'd3);
    row_cfg(REG_REPL_BYTES,    64'h0000_0000_0000_5958);
    row_cfg(REG_REPL_LEN,      64'd2);
    row_in("x", 1'b0);
    row_in("a", 1'b0);
    row_in("b", 1'b0);
    row_in("c", 1'b0);
    row_in("a", 1'b0);
    row_in("a", 1'b0);
    row_in("b", 1'b0);
    row_in("c", 1'b0);
    row_in("a", 1'b1);
    // deletion: a match on the last word leaves only the empty end marker
    row_cfg(REG_REPL_LEN, 64'd0);
    row_in("a", 1'b0);
    row_in("b", 1'b0);
    row_chk("c", 1'b1, 8'h00, 1'b0, 1'b1);
    // oversized lengths clamp to eight
    row_cfg(REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    row_cfg(REG_PATTERN_LEN,   64'd15);
    row_cfg(REG_REPL_BYTES,    64'hFF00_A55A_0F1E_7701);
    row_cfg(REG_REPL_LEN,      64'd15);
    for (k = 0; k < 8; k++) row_in(8'hFF, k == 7);
    // pattern shortened while two bytes are held
    row_in(8'hFF, 1'b0);
    row_in(8'hFF, 1'b0);
    row_cfg(REG_PATTERN_LEN, 64'd1);
    row_in(8'h00, 1'b1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        wait_idle();
        cfg_write(dir_rows[k].ridx, dir_rows[k].val);
      end else begin
        if (dir_rows[k].typed) begin
          predict_replace(dir_rows[k].b, dir_rows[k].l, 1'b0);
          out_words_due.push_back(dir_rows[k].want);
        end else begin
          predict_replace(dir_rows[k].b, dir_rows[k].l, 1'b1);
        end
        send_word(dir_rows[k].b, dir_rows[k].l);
      end
    end

    sent = 0;
    while (sent < 200) begin
      wait_idle();
      if ($urandom_range(0, 9) < 6) begin
        for (k = 0; k < 3; k++) alph[k] = octet_t'($urandom_range(0, 255));
        for (k = 0; k < 8; k++) v[8*k +: 8] = alph[$urandom_range(0, 2)];
        cfg_write(REG_PATTERN_BYTES, v);
      end
      if ($urandom_range(0, 9) < 6) begin
        r = $urandom_range(0, 99);
        v = (r < 10) ? 64'd0 : (r < 20) ? 64'($urandom_range(9, 15)) :
            (r < 40) ? 64'($urandom_range(5, 8)) : 64'($urandom_range(1, 4));
        cfg_write(REG_PATTERN_LEN, v);
      end
      if ($urandom_range(0, 9) < 5)
        cfg_write(REG_REPL_BYTES, {$urandom, $urandom});
      if ($urandom_range(0, 9) < 5) begin
        r = $urandom_range(0, 99);
        v = (r < 15) ? 64'd0 : (r < 25) ? 64'($urandom_range(9, 15)) :
            64'($urandom_range(1, 8));
        cfg_write(REG_REPL_LEN, v);
      end

      // text built around the current pattern, with some noise bytes
      plen = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
      len  = $urandom_range(3, 25);
      txt.delete();
      while (txt.size() < len) begin
        r = $urandom_range(0, 99);
        if (r < 30 && plen > 0) begin
          for (k = 0; k < plen; k++) txt.push_back(pat_bytes[8*k +: 8]);
        end else if (r < 85) begin
          k = $urandom_range(0, (plen > 0) ? plen - 1 : 7);
          txt.push_back(pat_bytes[8*k +: 8]);
        end else begin
          txt.push_back(octet_t'($urandom_range(0, 255)));
        end
      end
      with_last = ($urandom_range(0, 3) != 0);
      foreach (txt[k]) begin
        predict_replace(txt[k], with_last && (k == txt.size() - 1), 1'b1);
        send_word(txt[k], with_last && (k == txt.size() - 1));
      end
      sent += txt.size();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
